@@ rtl/core/pcb_pkg.sv @@
// Shared constants and types for the polygon convexity and bounding box block.
package pcb_pkg;

   localparam int PCB_MAX_VERTICES = 256;
   localparam int PCB_COORD_BITS   = 16;
   localparam int PCB_TOTAL_W      = 9;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_WALK,
      ST_DRAIN,
      ST_RESULT
   } pcb_state_type;

endpackage

@@ rtl/core/pcb_req_if.sv @@
// Vertex input channel: valid/ready handshake with one vertex per transaction.
interface pcb_req_if import pcb_pkg::*; #(
   parameter int COORD_BITS = PCB_COORD_BITS
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] vertex_x;
   logic signed [COORD_BITS-1:0] vertex_y;
   logic                         last_vertex;

   modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                   input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                   output ready);
endinterface

@@ rtl/core/pcb_rsp_if.sv @@
// Result channel: valid/ready handshake with one polygon summary per transaction.
interface pcb_rsp_if import pcb_pkg::*; #(
   parameter int COORD_BITS = PCB_COORD_BITS
) ();
   logic                         valid;
   logic                         ready;
   logic                         is_convex;
   logic signed [COORD_BITS-1:0] box_left;
   logic signed [COORD_BITS-1:0] box_top;
   logic        [COORD_BITS-1:0] box_width;
   logic        [COORD_BITS-1:0] box_height;
   logic        [PCB_TOTAL_W-1:0] vertex_total;
   logic                         overflow;

   modport source (output valid, output is_convex, output box_left, output box_top,
                   output box_width, output box_height, output vertex_total,
                   output overflow, input ready);
   modport sink   (input valid, input is_convex, input box_left, input box_top,
                   input box_width, input box_height, input vertex_total,
                   input overflow, output ready);
endinterface

@@ rtl/core/pcb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module pcb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/polygon_convexity_bbox_top.sv @@
// Polygon convexity test and bounding box: top level with vertex store and ring walk.
//
// Vertices arrive one transaction per cycle while the block is loading and are
// written into a single vertex RAM while the bounding box is tracked in
// registers. The vertex marked last is stored like any other and then starts
// the ring walk: the RAM's one read port delivers n+2 words (the last vertex,
// all n in order, then the first again), a three-entry window forms each
// vertex's previous/next edges, and a three-stage pipeline (edges, two
// multipliers, compare) reduces the cross product signs. The pipeline drains
// after the walk before the result of a polygon of n >= 3 vertices is offered.
// With fewer than three vertices the result is offered the cycle after the
// last vertex. Input is not taken while a result waits; after the result
// transaction the count, box, overflow flag and walk state are cleared.
// Vertices beyond MAX_VERTICES are dropped and reported through overflow.
module polygon_convexity_bbox_top import pcb_pkg::*; #(
   parameter int MAX_VERTICES = PCB_MAX_VERTICES,
   parameter int COORD_BITS   = PCB_COORD_BITS
) (
   input  logic       clock,
   input  logic       reset,
   pcb_req_if.sink    req_if,
   pcb_rsp_if.source  rsp_if
);
   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 2);
   localparam int WORD_W = 2 * COORD_BITS;
   localparam int EDGE_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * EDGE_W;
   localparam int DIFF_W = PROD_W + 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   pcb_state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   coord_type        min_x_ff, min_x_in, min_y_ff, min_y_in;
   coord_type        max_x_ff, max_x_in, max_y_ff, max_y_in;
   logic             dropped_ff, dropped_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [1:0]       recv_ff, recv_in;
   logic             pos_ff, pos_in, neg_ff, neg_in;

   logic             rd_vld_ff, win_vld_ff, edge_vld_ff, prod_vld_ff;
   coord_type        win_x_ff [3];
   coord_type        win_y_ff [3];
   logic signed [EDGE_W-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [PROD_W-1:0] prod_p_ff, prod_q_ff;
   logic signed [DIFF_W-1:0] diff;

   logic              req_acc, rsp_acc, has_room, last_read;
   logic              rd_en;
   logic [CNT_W-1:0]  rd_addr_full;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              pipe_empty;

   assign req_acc    = req_if.valid && req_if.ready;
   assign rsp_acc    = rsp_if.valid && rsp_if.ready;
   assign has_room   = count_ff < CNT_W'(MAX_VERTICES);
   assign last_read  = rd_idx_ff == count_ff + CNT_W'(1);
   assign pipe_empty = !rd_vld_ff && !win_vld_ff && !edge_vld_ff && !prod_vld_ff;

   // Ring order: last vertex, then 0..n-1, then vertex 0 again.
   always_comb begin
      if (rd_idx_ff == '0) begin
         rd_addr_full = count_ff - CNT_W'(1);
      end else if (last_read) begin
         rd_addr_full = '0;
      end else begin
         rd_addr_full = rd_idx_ff - CNT_W'(1);
      end
   end
   assign rd_addr = rd_addr_full[ADDR_W-1:0];

   pcb_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (req_acc && has_room),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req_if.vertex_x, req_if.vertex_y}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_acc && req_if.last_vertex) begin
               state_in = (count_in >= CNT_W'(3)) ? ST_WALK : ST_RESULT;
            end
         end
         ST_WALK: begin
            if (last_read) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_acc) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // State outputs
   always_comb begin
      req_if.ready = 1'b0;
      rsp_if.valid = 1'b0;
      rd_en        = 1'b0;
      case (state_ff)
         ST_LOAD:   req_if.ready = 1'b1;
         ST_WALK:   rd_en        = 1'b1;
         ST_DRAIN:  ;
         ST_RESULT: rsp_if.valid = 1'b1;
         default:   ;
      endcase
   end

   // Box, count and walk bookkeeping
   always_comb begin
      count_in   = count_ff;
      min_x_in   = min_x_ff;
      min_y_in   = min_y_ff;
      max_x_in   = max_x_ff;
      max_y_in   = max_y_ff;
      dropped_in = dropped_ff;
      rd_idx_in  = rd_idx_ff;
      recv_in    = recv_ff;
      pos_in     = pos_ff;
      neg_in     = neg_ff;

      if (req_acc) begin
         if (has_room) begin
            count_in = count_ff + CNT_W'(1);
            if (count_ff == '0) begin
               min_x_in = req_if.vertex_x;
               max_x_in = req_if.vertex_x;
               min_y_in = req_if.vertex_y;
               max_y_in = req_if.vertex_y;
            end else begin
               if (req_if.vertex_x < min_x_ff) min_x_in = req_if.vertex_x;
               if (req_if.vertex_x > max_x_ff) max_x_in = req_if.vertex_x;
               if (req_if.vertex_y < min_y_ff) min_y_in = req_if.vertex_y;
               if (req_if.vertex_y > max_y_ff) max_y_in = req_if.vertex_y;
            end
         end else begin
            dropped_in = 1'b1;
         end
      end

      if (rd_en) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
      end
      if (rd_vld_ff && recv_ff != 2'd2) begin
         recv_in = recv_ff + 2'd1;
      end
      if (prod_vld_ff) begin
         if (diff > 0) pos_in = 1'b1;
         if (diff < 0) neg_in = 1'b1;
      end

      if (rsp_acc) begin
         count_in   = '0;
         min_x_in   = '0;
         min_y_in   = '0;
         max_x_in   = '0;
         max_y_in   = '0;
         dropped_in = 1'b0;
         rd_idx_in  = '0;
         recv_in    = '0;
         pos_in     = 1'b0;
         neg_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         count_ff    <= '0;
         min_x_ff    <= '0;
         min_y_ff    <= '0;
         max_x_ff    <= '0;
         max_y_ff    <= '0;
         dropped_ff  <= 1'b0;
         rd_idx_ff   <= '0;
         recv_ff     <= '0;
         pos_ff      <= 1'b0;
         neg_ff      <= 1'b0;
         rd_vld_ff   <= 1'b0;
         win_vld_ff  <= 1'b0;
         edge_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         min_x_ff    <= min_x_in;
         min_y_ff    <= min_y_in;
         max_x_ff    <= max_x_in;
         max_y_ff    <= max_y_in;
         dropped_ff  <= dropped_in;
         rd_idx_ff   <= rd_idx_in;
         recv_ff     <= recv_in;
         pos_ff      <= pos_in;
         neg_ff      <= neg_in;
         rd_vld_ff   <= rd_en;
         win_vld_ff  <= rd_vld_ff && recv_ff == 2'd2;
         edge_vld_ff <= win_vld_ff;
         prod_vld_ff <= edge_vld_ff;
      end
   end

   // Datapath: window of previous/current/next vertex, edges, products
   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         win_x_ff[0] <= win_x_ff[1];
         win_y_ff[0] <= win_y_ff[1];
         win_x_ff[1] <= win_x_ff[2];
         win_y_ff[1] <= win_y_ff[2];
         win_x_ff[2] <= rd_data[WORD_W-1:COORD_BITS];
         win_y_ff[2] <= rd_data[COORD_BITS-1:0];
      end
      if (win_vld_ff) begin
         ax_ff <= EDGE_W'(win_x_ff[0]) - EDGE_W'(win_x_ff[1]);
         ay_ff <= EDGE_W'(win_y_ff[0]) - EDGE_W'(win_y_ff[1]);
         bx_ff <= EDGE_W'(win_x_ff[2]) - EDGE_W'(win_x_ff[1]);
         by_ff <= EDGE_W'(win_y_ff[2]) - EDGE_W'(win_y_ff[1]);
      end
      if (edge_vld_ff) begin
         prod_p_ff <= ax_ff * by_ff;
         prod_q_ff <= ay_ff * bx_ff;
      end
   end

   assign diff = DIFF_W'(prod_p_ff) - DIFF_W'(prod_q_ff);

   assign rsp_if.is_convex    = (count_ff >= CNT_W'(3)) && !(pos_ff && neg_ff);
   assign rsp_if.box_left     = min_x_ff;
   assign rsp_if.box_top      = min_y_ff;
   assign rsp_if.box_width    = max_x_ff - min_x_ff;
   assign rsp_if.box_height   = max_y_ff - min_y_ff;
   assign rsp_if.vertex_total = PCB_TOTAL_W'(count_ff);
   assign rsp_if.overflow     = dropped_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VERTICES))
      else $error("stored vertex count exceeds capacity");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("input taken while a result is pending");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> rd_addr_full < count_ff)
      else $error("ring walk reads beyond stored vertices");

   a_clear_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |=> (count_ff == '0 && !dropped_ff && !pos_ff && !neg_ff))
      else $error("state not cleared after result transaction");

   a_pipe_idle_at_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> pipe_empty)
      else $error("result offered while cross products still in flight");
`endif
endmodule
